// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker in ldt_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ldt_pkg.sv =====
package ldt_pkg;

    // Rec.709 luma weights, Q0.16, summing to 65536
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam logic [8:0] FULL_AMOUNT = 9'd256;

    // Register indexes on the config port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_AMT   = 3'd6;

    // Number of register stages from input to result
    localparam int PIPE_DEPTH = 5;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    typedef logic [7:0] chan_t;

endpackage

// ===== rtl/luma_duotone_tint_top.sv =====
// Channel   Dir   Handshake                 Moves
// s_        in    s_valid / s_ready         one RGBA pixel word
// m_        out   m_valid / m_ready         one tinted RGBA pixel word
// cfg_      in    cfg_wr_en, no wait        one register write
//
// Five register stages; a word passes through them in order, and a new word
// can be taken on every clock unless m_ready stalls it (one pixel per cycle).
// Reset (aresetn low at a clock edge) empties the pipeline and restores
// the default map: black to white, full tint.
// Each stage holds its word until the next stage is free, so a stall on
// m_ready fills the bubbles first and only then drops s_ready.
module luma_duotone_tint_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ldt_pkg::pixel_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ldt_pkg::pixel_out_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [ldt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ldt_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    chan_t      black_red_reg, black_green_reg, black_blue_reg;
    chan_t      white_red_reg, white_green_reg, white_blue_reg;
    logic [8:0] blend_amt_reg;
    logic [8:0] amt;       // amount saturated to full
    logic [8:0] inv_amt;   // 256 - amt

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_red_reg   <= 8'd0;
            black_green_reg <= 8'd0;
            black_blue_reg  <= 8'd0;
            white_red_reg   <= 8'd255;
            white_green_reg <= 8'd255;
            white_blue_reg  <= 8'd255;
            blend_amt_reg   <= FULL_AMOUNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BLACK_RED:   black_red_reg   <= cfg_wdata[7:0];
                CFG_BLACK_GREEN: black_green_reg <= cfg_wdata[7:0];
                CFG_BLACK_BLUE:  black_blue_reg  <= cfg_wdata[7:0];
                CFG_WHITE_RED:   white_red_reg   <= cfg_wdata[7:0];
                CFG_WHITE_GREEN: white_green_reg <= cfg_wdata[7:0];
                CFG_WHITE_BLUE:  white_blue_reg  <= cfg_wdata[7:0];
                CFG_BLEND_AMT:   blend_amt_reg   <= cfg_wdata;
                default: ;       // unmapped index, write dropped
            endcase
        end
    end

    // The user must change registers only while idle (not enforced here); later stages read them directly.
    assign amt     = (blend_amt_reg > FULL_AMOUNT) ? FULL_AMOUNT : blend_amt_reg;
    assign inv_amt = FULL_AMOUNT - amt;

    // ---------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or its
    // successor is loading. Ready ripples back from the output.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = m_ready || !v5_reg;
    assign rdy4 = rdy5 || !v4_reg;
    assign rdy3 = rdy4 || !v3_reg;
    assign rdy2 = rdy3 || !v2_reg;
    assign rdy1 = rdy2 || !v1_reg;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: weighted luma products
    // ---------------------------------------------------------------
    pixel_in_t   px1_reg;
    logic [23:0] pr_reg, pg_reg, pb_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            px1_reg <= s_data;
            pr_reg  <= 24'(W_RED   * s_data.red_in);
            pg_reg  <= 24'(W_GREEN * s_data.green_in);
            pb_reg  <= 24'(W_BLUE  * s_data.blue_in);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: luma. Weights sum to 1.0, so the top byte never overflows.
    // ---------------------------------------------------------------
    pixel_in_t   px2_reg;
    chan_t       luma2_reg;
    logic [23:0] luma_sum;

    assign luma_sum = pr_reg + pg_reg + pb_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            px2_reg   <= px1_reg;
            luma2_reg <= luma_sum[23:16];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: tint (scaled by 255) and the source share per channel
    // ---------------------------------------------------------------
    logic [7:0]  alpha3_reg;
    logic [15:0] tint_r3_reg, tint_g3_reg, tint_b3_reg;
    logic [24:0] src_r3_reg, src_g3_reg, src_b3_reg;
    chan_t       luma_inv;

    assign luma_inv = ~luma2_reg;   // 255 - luma

    function automatic logic [15:0] tint_of(input chan_t blk, input chan_t wht,
                                            input chan_t l, input chan_t l_inv);
        logic [15:0] p_blk;
        logic [15:0] p_wht;
        p_blk = blk * l_inv;
        p_wht = wht * l;
        return p_blk + p_wht;
    endfunction

    function automatic logic [24:0] src_share(input chan_t src, input logic [8:0] ia);
        logic [15:0] s255;
        s255 = {src, 8'd0} - {8'd0, src};
        return s255 * ia;
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            alpha3_reg  <= px2_reg.alpha_in;
            tint_r3_reg <= tint_of(black_red_reg, white_red_reg, luma2_reg, luma_inv);
            tint_g3_reg <= tint_of(black_green_reg, white_green_reg, luma2_reg, luma_inv);
            tint_b3_reg <= tint_of(black_blue_reg, white_blue_reg, luma2_reg, luma_inv);
            src_r3_reg  <= src_share(px2_reg.red_in, inv_amt);
            src_g3_reg  <= src_share(px2_reg.green_in, inv_amt);
            src_b3_reg  <= src_share(px2_reg.blue_in, inv_amt);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: mixed sum, at most 255 * 65280
    // ---------------------------------------------------------------
    logic [7:0]  alpha4_reg;
    logic [24:0] sum_r4_reg, sum_g4_reg, sum_b4_reg;

    function automatic logic [24:0] mix_sum(input logic [15:0] t, input logic [8:0] a,
                                            input logic [24:0] s);
        logic [24:0] ta;
        ta = t * a;
        return ta + s;
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            alpha4_reg <= alpha3_reg;
            sum_r4_reg <= mix_sum(tint_r3_reg, amt, src_r3_reg);
            sum_g4_reg <= mix_sum(tint_g3_reg, amt, src_g3_reg);
            sum_b4_reg <= mix_sum(tint_b3_reg, amt, src_b3_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: divide by 65280 = 256 * 255, clamp. The /256 is a shift;
    // x/255 for 16-bit x is ((x+1) + ((x+1) >> 8)) >> 8, exact.
    // ---------------------------------------------------------------
    pixel_out_t out5_reg;

    function automatic chan_t div_clamp(input logic [24:0] s);
        logic [17:0] x1;
        logic [17:0] q;
        x1 = {1'b0, s[24:8]} + 18'd1;
        q  = (x1 + (x1 >> 8)) >> 8;
        return (q > 18'd255) ? 8'd255 : q[7:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            out5_reg.red_out   <= div_clamp(sum_r4_reg);
            out5_reg.green_out <= div_clamp(sum_g4_reg);
            out5_reg.blue_out  <= div_clamp(sum_b4_reg);
            out5_reg.alpha_out <= alpha4_reg;
        end
    end

    assign m_valid = v5_reg;
    assign m_data  = out5_reg;

endmodule

// ===== rtl/ldt_chk.sv =====
`include "assert_macros.svh"

module ldt_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input ldt_pkg::pixel_out_t            m_data,
    input logic                           cfg_wr_en,
    input logic [ldt_pkg::CFG_IDX_W-1:0]  cfg_index
);
    import ldt_pkg::*;

    // words taken but not yet delivered
    logic [3:0] cnt_reg, cnt_next;
    logic       s_fire, m_fire;
    logic       m_stall;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign m_stall = m_valid && !m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_fire && !m_fire) cnt_next = cnt_reg + 4'd1;
        if (!s_fire && m_fire) cnt_next = cnt_reg - 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_CLK_NR(a_reset_empties, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_stall |=> m_valid && $stable(m_data), "word lost")
    `ASSERT_CLK(a_no_phantom, aclk, aresetn, m_valid |-> cnt_reg != 4'd0, "word from nowhere")
    `ASSERT_CLK(a_depth_bound, aclk, aresetn, cnt_reg <= 4'(PIPE_DEPTH), "pipeline overfull")

    // a write must carry an index free of X or Z bits
    `ASSERT_CLK(a_cfg_known, aclk, aresetn, cfg_wr_en |-> !$isunknown(cfg_index), "config index X")

endmodule

bind luma_duotone_tint_top ldt_chk u_ldt_chk (.*);
